/* src/dtlv_pkg.sv */
// Shared types and constants of the DER TLV header parser.
// Used by dtlv_step, der_tlv_header_parser_core, the checker and the testbench; depends on nothing.
package dtlv_pkg;

   // parser phase
   typedef enum logic [1:0] {
      PH_TAG  = 2'd0,
      PH_LEN  = 2'd1,
      PH_LONG = 2'd2,
      PH_BODY = 2'd3
   } dtlv_phase_type;

   // byte class codes
   localparam logic [1:0] CLS_TAG  = 2'd0;
   localparam logic [1:0] CLS_LEN  = 2'd1;
   localparam logic [1:0] CLS_BODY = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INDEF    = 3'd1;
   localparam logic [2:0] ST_TOOMANY  = 3'd2;
   localparam logic [2:0] ST_NONMIN   = 3'd3;
   localparam logic [2:0] ST_MISMATCH = 3'd4;
   localparam logic [2:0] ST_TRUNC    = 3'd5;

   // command codes
   localparam logic CMD_ANY   = 1'b0;
   localparam logic CMD_MATCH = 1'b1;

   // one result item
   typedef struct packed {
      logic [1:0]  byte_class;
      logic [7:0]  data_out;
      logic        header_done;
      logic [7:0]  tag_out;
      logic [31:0] length_out;
      logic        element_done;
      logic [2:0]  status;
   } dtlv_result_type;

endpackage

/* src/dtlv_step.sv */
// Per-byte decode of the DER TLV header parser: next state and result item.
// Purely combinational; uses dtlv_pkg.
module dtlv_step #(
   parameter int MAX_LEN_OCTETS = 4
) (
   input  logic [7:0]                             data_byte,
   input  logic                                   command,
   input  logic [7:0]                             required_tag,
   input  logic                                   end_of_input,
   input  dtlv_pkg::dtlv_phase_type               phase_ff,
   input  logic [7:0]                             held_tag_ff,
   input  logic [31:0]                            length_accum_ff,
   input  logic [$clog2(MAX_LEN_OCTETS+1)-1:0]    octets_left_ff,
   input  logic [$clog2(MAX_LEN_OCTETS+1)-1:0]    octets_total_ff,
   input  logic                                   first_octet_zero_ff,
   input  logic [31:0]                            content_left_ff,
   output dtlv_pkg::dtlv_phase_type               phase_in,
   output logic [7:0]                             held_tag_in,
   output logic [31:0]                            length_accum_in,
   output logic [$clog2(MAX_LEN_OCTETS+1)-1:0]    octets_left_in,
   output logic [$clog2(MAX_LEN_OCTETS+1)-1:0]    octets_total_in,
   output logic                                   first_octet_zero_in,
   output logic [31:0]                            content_left_in,
   output dtlv_pkg::dtlv_result_type              result
);

   localparam int CntW = $clog2(MAX_LEN_OCTETS + 1);
   localparam logic [6:0] MaxOct = 7'(MAX_LEN_OCTETS);

   logic            do_finish;
   logic            do_drop;
   logic [31:0]     fin_len;
   logic [CntW-1:0] left_dec;
   logic [31:0]     content_dec;

   always_comb begin
      phase_in            = phase_ff;
      held_tag_in         = held_tag_ff;
      length_accum_in     = length_accum_ff;
      octets_left_in      = octets_left_ff;
      octets_total_in     = octets_total_ff;
      first_octet_zero_in = first_octet_zero_ff;
      content_left_in     = content_left_ff;
      do_finish           = 1'b0;
      do_drop             = 1'b0;
      fin_len             = 32'd0;
      left_dec            = octets_left_ff;
      content_dec         = content_left_ff;

      result.byte_class   = dtlv_pkg::CLS_TAG;
      result.data_out     = data_byte;
      result.header_done  = 1'b0;
      result.length_out   = 32'd0;
      result.element_done = 1'b0;
      result.status       = dtlv_pkg::ST_OK;

      case (phase_ff)
         // tag byte: optional tag check
         dtlv_pkg::PH_TAG: begin
            result.byte_class = dtlv_pkg::CLS_TAG;
            held_tag_in = data_byte;
            if (command == dtlv_pkg::CMD_MATCH && data_byte != required_tag) begin
               result.status = dtlv_pkg::ST_MISMATCH;
               do_drop = 1'b1;
            end else if (end_of_input) begin
               result.status = dtlv_pkg::ST_TRUNC;
               do_drop = 1'b1;
            end else begin
               phase_in = dtlv_pkg::PH_LEN;
            end
         end
         // first length byte: short form or long-form count
         dtlv_pkg::PH_LEN: begin
            result.byte_class = dtlv_pkg::CLS_LEN;
            if (!data_byte[7]) begin
               do_finish = 1'b1;
               fin_len   = {24'd0, data_byte};
            end else if (data_byte[6:0] == 7'd0) begin
               result.status = dtlv_pkg::ST_INDEF;
               do_drop = 1'b1;
            end else if (data_byte[6:0] > MaxOct) begin
               result.status = dtlv_pkg::ST_TOOMANY;
               do_drop = 1'b1;
            end else begin
               octets_total_in     = CntW'(data_byte[6:0]);
               octets_left_in      = CntW'(data_byte[6:0]);
               length_accum_in     = 32'd0;
               first_octet_zero_in = 1'b0;
               phase_in            = dtlv_pkg::PH_LONG;
               if (end_of_input) begin
                  result.status = dtlv_pkg::ST_TRUNC;
                  do_drop = 1'b1;
               end
            end
         end
         // long-form length octets, big-endian
         dtlv_pkg::PH_LONG: begin
            result.byte_class = dtlv_pkg::CLS_LEN;
            first_octet_zero_in = first_octet_zero_ff |
               ((octets_left_ff == octets_total_ff) && (data_byte == 8'd0));
            if (length_accum_ff[31:24] != 8'd0) begin
               result.status = dtlv_pkg::ST_TOOMANY;
               do_drop = 1'b1;
            end else begin
               length_accum_in = {length_accum_ff[23:0], data_byte};
               if (octets_left_ff != '0) begin
                  left_dec = octets_left_ff - CntW'(1);
               end
               octets_left_in = left_dec;
               if (left_dec == '0) begin
                  if (octets_total_ff > CntW'(1) && first_octet_zero_in) begin
                     result.status = dtlv_pkg::ST_NONMIN;
                     do_drop = 1'b1;
                  end else begin
                     do_finish = 1'b1;
                     fin_len   = {length_accum_ff[23:0], data_byte};
                  end
               end else if (end_of_input) begin
                  result.status = dtlv_pkg::ST_TRUNC;
                  do_drop = 1'b1;
               end
            end
         end
         // content bytes
         default: begin
            result.byte_class = dtlv_pkg::CLS_BODY;
            if (content_left_ff != 32'd0) begin
               content_dec = content_left_ff - 32'd1;
            end
            content_left_in = content_dec;
            if (content_dec == 32'd0) begin
               result.element_done = 1'b1;
               do_drop = 1'b1;
            end else if (end_of_input) begin
               result.status = dtlv_pkg::ST_TRUNC;
               do_drop = 1'b1;
            end
         end
      endcase

      // header complete
      if (do_finish) begin
         result.header_done = 1'b1;
         result.length_out  = fin_len;
         if (fin_len == 32'd0) begin
            result.element_done = 1'b1;
            do_drop = 1'b1;
         end else begin
            content_left_in = fin_len;
            phase_in        = dtlv_pkg::PH_BODY;
            if (end_of_input) begin
               result.status      = dtlv_pkg::ST_TRUNC;
               result.header_done = 1'b0;
               result.length_out  = 32'd0;
               do_drop = 1'b1;
            end
         end
      end

      // drop element, wait for next tag
      if (do_drop) begin
         phase_in            = dtlv_pkg::PH_TAG;
         length_accum_in     = 32'd0;
         octets_left_in      = '0;
         octets_total_in     = '0;
         first_octet_zero_in = 1'b0;
         content_left_in     = 32'd0;
      end

      result.tag_out = held_tag_in;
   end

endmodule

/* src/der_tlv_header_parser_core.sv */
// Top level of the DER TLV header parser: input register, parser state, result register.
// Uses dtlv_pkg and dtlv_step.
//
// Takes a DER stream one byte per item and gives exactly one result item per byte:
// the byte echoed with its class, the element tag, the decoded length on the byte
// that completes the header, element_done on an element's last byte, and a status
// code on errors (after which the parser waits for a new tag). Throughput is one
// byte per cycle while rsp_ready keeps the result register draining; each byte
// passes through the input register and then the result register before its
// result item is offered on rsp_valid. The parser state is updated in the same
// cycle the byte moves from the input register into the result register.
// MAX_LEN_OCTETS (1 to 8) bounds the number of long-form length octets.
module der_tlv_header_parser_core #(
   parameter int MAX_LEN_OCTETS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_command,
   input  logic [7:0]  req_required_tag,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_byte_class,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_header_done,
   output logic [7:0]  rsp_tag_out,
   output logic [31:0] rsp_length_out,
   output logic        rsp_element_done,
   output logic [2:0]  rsp_status
);

   localparam int CntW = $clog2(MAX_LEN_OCTETS + 1);

   // input register
   logic        in_valid_ff;
   logic [7:0]  data_byte_ff;
   logic        command_ff;
   logic [7:0]  required_tag_ff;
   logic        end_of_input_ff;

   // parser state
   dtlv_pkg::dtlv_phase_type phase_ff, phase_in;
   logic [7:0]      held_tag_ff, held_tag_in;
   logic [31:0]     length_accum_ff, length_accum_in;
   logic [CntW-1:0] octets_left_ff, octets_left_in;
   logic [CntW-1:0] octets_total_ff, octets_total_in;
   logic            first_octet_zero_ff, first_octet_zero_in;
   logic [31:0]     content_left_ff, content_left_in;

   // result register
   logic                      out_valid_ff;
   dtlv_pkg::dtlv_result_type result_ff;
   dtlv_pkg::dtlv_result_type result_in;

   logic advance;

   // handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_byte_ff    <= req_data_byte;
         command_ff      <= req_command;
         required_tag_ff <= req_required_tag;
         end_of_input_ff <= req_end_of_input;
      end
   end

   // per-byte decode
   dtlv_step #(
      .MAX_LEN_OCTETS(MAX_LEN_OCTETS)
   ) u_step (
      .data_byte           (data_byte_ff),
      .command             (command_ff),
      .required_tag        (required_tag_ff),
      .end_of_input        (end_of_input_ff),
      .phase_ff            (phase_ff),
      .held_tag_ff         (held_tag_ff),
      .length_accum_ff     (length_accum_ff),
      .octets_left_ff      (octets_left_ff),
      .octets_total_ff     (octets_total_ff),
      .first_octet_zero_ff (first_octet_zero_ff),
      .content_left_ff     (content_left_ff),
      .phase_in            (phase_in),
      .held_tag_in         (held_tag_in),
      .length_accum_in     (length_accum_in),
      .octets_left_in      (octets_left_in),
      .octets_total_in     (octets_total_in),
      .first_octet_zero_in (first_octet_zero_in),
      .content_left_in     (content_left_in),
      .result              (result_in)
   );

   // parser state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= dtlv_pkg::PH_TAG;
         held_tag_ff         <= 8'd0;
         length_accum_ff     <= 32'd0;
         octets_left_ff      <= '0;
         octets_total_ff     <= '0;
         first_octet_zero_ff <= 1'b0;
         content_left_ff     <= 32'd0;
      end else if (advance) begin
         phase_ff            <= phase_in;
         held_tag_ff         <= held_tag_in;
         length_accum_ff     <= length_accum_in;
         octets_left_ff      <= octets_left_in;
         octets_total_ff     <= octets_total_in;
         first_octet_zero_ff <= first_octet_zero_in;
         content_left_ff     <= content_left_in;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_class   = result_ff.byte_class;
   assign rsp_data_out     = result_ff.data_out;
   assign rsp_header_done  = result_ff.header_done;
   assign rsp_tag_out      = result_ff.tag_out;
   assign rsp_length_out   = result_ff.length_out;
   assign rsp_element_done = result_ff.element_done;
   assign rsp_status       = result_ff.status;

   // a reported header never carries an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_done |-> rsp_status == dtlv_pkg::ST_OK)
      else $error("header_done with error status");

   // element ending on a length byte is a zero-length header
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_element_done && rsp_byte_class == dtlv_pkg::CLS_LEN
      |-> rsp_header_done && rsp_length_out == 32'd0)
      else $error("element_done on length byte without empty header");

   // content phase always has bytes left
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == dtlv_pkg::PH_BODY |-> content_left_ff != 32'd0)
      else $error("content phase with zero bytes left");

   // long-form phase always has octets left
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == dtlv_pkg::PH_LONG |-> octets_left_ff != '0)
      else $error("long-form phase with no octets left");

endmodule

/* dv/der_tlv_header_parser_checker.sv */
// Checker for der_tlv_header_parser_core: watches both channels, predicts each result item.
// Depends on dtlv_pkg for the phase, class, status and command codes and the result struct.
module der_tlv_header_parser_checker #(
   parameter int MAX_LEN_OCTETS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_command,
   input  logic [7:0]  req_required_tag,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_byte_class,
   input  logic [7:0]  rsp_data_out,
   input  logic        rsp_header_done,
   input  logic [7:0]  rsp_tag_out,
   input  logic [31:0] rsp_length_out,
   input  logic        rsp_element_done,
   input  logic [2:0]  rsp_status,
   output int          fail_count,
   output int          queued_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // parser state as predicted
   dtlv_pkg::dtlv_phase_type ph_q = dtlv_pkg::PH_TAG;
   logic [7:0]      tag_q = '0;
   logic [31:0]     accum_q = '0;
   logic [3:0]      octets_left_q = '0;
   logic [3:0]      octets_total_q = '0;
   logic            zero_first_q = 1'b0;
   logic [31:0]     body_left_q = '0;

   dtlv_pkg::dtlv_result_type parsed_byte_q [$];
   int              fail_total = 0;

   assign fail_count = fail_total;

   // abandon the element, wait for a new tag
   task drop_element();
      ph_q = dtlv_pkg::PH_TAG;
      accum_q = '0;
      octets_left_q = '0;
      octets_total_q = '0;
      zero_first_q = 1'b0;
      body_left_q = '0;
   endtask

   // header complete: zero length ends the element, else move to content (truncated at end of input)
   task close_header(input logic [31:0] len, input logic eoi,
                     inout dtlv_pkg::dtlv_result_type r);
      if (len == 32'd0) begin
         r.header_done = 1'b1;
         r.element_done = 1'b1;
         drop_element();
      end else begin
         body_left_q = len;
         ph_q = dtlv_pkg::PH_BODY;
         if (eoi) begin
            r.status = dtlv_pkg::ST_TRUNC;
            drop_element();
         end else begin
            r.header_done = 1'b1;
            r.length_out = len;
         end
      end
   endtask

   // next state and result item for one stream byte
   task parse_der_byte(input logic [7:0] b, input logic cmd, input logic [7:0] xtag,
                       input logic eoi, output dtlv_pkg::dtlv_result_type r);
      r = '0;
      r.data_out = b;
      case (ph_q)
         dtlv_pkg::PH_TAG: begin
            r.byte_class = dtlv_pkg::CLS_TAG;
            tag_q = b;
            if (cmd == dtlv_pkg::CMD_MATCH && b != xtag) begin
               r.status = dtlv_pkg::ST_MISMATCH;
               drop_element();
            end else if (eoi) begin
               r.status = dtlv_pkg::ST_TRUNC;
               drop_element();
            end else begin
               ph_q = dtlv_pkg::PH_LEN;
            end
         end
         dtlv_pkg::PH_LEN: begin
            r.byte_class = dtlv_pkg::CLS_LEN;
            if (!b[7]) begin
               close_header({24'd0, b}, eoi, r);
            end else if (b[6:0] == 7'd0) begin
               r.status = dtlv_pkg::ST_INDEF;
               drop_element();
            end else if (int'(b[6:0]) > MAX_LEN_OCTETS) begin
               r.status = dtlv_pkg::ST_TOOMANY;
               drop_element();
            end else begin
               octets_total_q = b[3:0];
               octets_left_q = b[3:0];
               accum_q = '0;
               zero_first_q = 1'b0;
               ph_q = dtlv_pkg::PH_LONG;
               if (eoi) begin
                  r.status = dtlv_pkg::ST_TRUNC;
                  drop_element();
               end
            end
         end
         dtlv_pkg::PH_LONG: begin
            r.byte_class = dtlv_pkg::CLS_LEN;
            if (octets_left_q == octets_total_q && b == 8'd0) zero_first_q = 1'b1;
            // length no longer fits in 32 bits
            if (accum_q > 32'h00FF_FFFF) begin
               r.status = dtlv_pkg::ST_TOOMANY;
               drop_element();
            end else begin
               accum_q = {accum_q[23:0], b};
               if (octets_left_q != 4'd0) octets_left_q = octets_left_q - 4'd1;
               if (octets_left_q == 4'd0) begin
                  if (octets_total_q > 4'd1 && zero_first_q) begin
                     r.status = dtlv_pkg::ST_NONMIN;
                     drop_element();
                  end else begin
                     close_header(accum_q, eoi, r);
                  end
               end else if (eoi) begin
                  r.status = dtlv_pkg::ST_TRUNC;
                  drop_element();
               end
            end
         end
         default: begin
            r.byte_class = dtlv_pkg::CLS_BODY;
            if (body_left_q != 32'd0) body_left_q = body_left_q - 32'd1;
            if (body_left_q == 32'd0) begin
               r.element_done = 1'b1;
               drop_element();
            end else if (eoi) begin
               r.status = dtlv_pkg::ST_TRUNC;
               drop_element();
            end
         end
      endcase
      r.tag_out = tag_q;
   endtask

   task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         fail_total++;
      end
   endtask

   // predict on each accepted byte, compare each accepted result item
   always @(posedge clock) begin : watch
      dtlv_pkg::dtlv_result_type want;
      if (reset) begin
         drop_element();
         tag_q = '0;
         parsed_byte_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            parse_der_byte(req_data_byte, req_command, req_required_tag, req_end_of_input,
                           want);
            parsed_byte_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (parsed_byte_q.size() == 0) begin
               $display("%0t: unexpected result item, expected none actual data_out %0h",
                        $time, rsp_data_out);
               fail_total++;
            end else begin
               want = parsed_byte_q.pop_front();
               check_field("byte_class", 32'(want.byte_class), 32'(rsp_byte_class));
               check_field("data_out", 32'(want.data_out), 32'(rsp_data_out));
               check_field("header_done", 32'(want.header_done), 32'(rsp_header_done));
               check_field("tag_out", 32'(want.tag_out), 32'(rsp_tag_out));
               check_field("length_out", want.length_out, rsp_length_out);
               check_field("element_done", 32'(want.element_done), 32'(rsp_element_done));
               check_field("status", 32'(want.status), 32'(rsp_status));
            end
         end
      end
      queued_count <= parsed_byte_q.size();
   end

endmodule

/* dv/tb_der_tlv_header_parser_core.sv */
// Testbench top for der_tlv_header_parser_core: clock, reset, byte stream stimulus, verdict.
// Depends on dtlv_pkg, the core and der_tlv_header_parser_checker.
module tb_der_tlv_header_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_OCTETS   = 4;
   localparam int RANDOM_ITEMS = 1200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_command = dtlv_pkg::CMD_ANY;
   logic [7:0]  req_required_tag = '0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_byte_class;
   logic [7:0]  rsp_data_out;
   logic        rsp_header_done;
   logic [7:0]  rsp_tag_out;
   logic [31:0] rsp_length_out;
   logic        rsp_element_done;
   logic [2:0]  rsp_status;

   int tx_idle_pct = 37;
   int rx_idle_pct = 63;
   int items_sent = 0;
   int fail_count;
   int queued_count;

   always #5 clock = ~clock;

   // receiver stalls
   always @(posedge clock) rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

   der_tlv_header_parser_core #(.MAX_LEN_OCTETS(MAX_OCTETS)) i_dut (.*);

   der_tlv_header_parser_checker #(.MAX_LEN_OCTETS(MAX_OCTETS)) i_checker (.*);

   // hard stop
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // one byte item, with random sender gaps in front
   task send_item(input logic [7:0] b, input logic cmd, input logic [7:0] xtag,
                  input logic eoi);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_command <= cmd;
      req_required_tag <= xtag;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // sender holds off until every result item has come back
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (queued_count != 0) @(posedge clock);
   endtask

   // well-formed element with random content, sometimes cut short or mismatched
   task send_element();
      logic [7:0]  tag;
      logic [7:0]  xtag;
      logic        cmd;
      logic [7:0]  hdr [$];
      logic [31:0] body_len;
      logic [7:0]  b;
      logic        eoi;
      int          n;
      int          cut;
      int          total;
      int          pick;
      tag = 8'($urandom);
      cmd = 1'($urandom);
      xtag = (cmd == dtlv_pkg::CMD_MATCH && $urandom_range(0, 9) == 0) ? 8'($urandom) : tag;
      hdr.push_back(tag);
      cut = -1;
      body_len = 0;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 127) : $urandom_range(0, 15);
         hdr.push_back(body_len[7:0]);
      end else if (pick < 8) begin
         body_len = ($urandom_range(0, 3) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 20);
         hdr.push_back(8'h81);
         hdr.push_back(body_len[7:0]);
      end else if (pick == 8) begin
         body_len = $urandom_range(256, 300);
         hdr.push_back(8'h82);
         hdr.push_back(body_len[15:8]);
         hdr.push_back(body_len[7:0]);
      end else begin
         // huge length: always cut the content short
         n = $urandom_range(3, MAX_OCTETS);
         hdr.push_back(8'h80 | 8'(n));
         hdr.push_back(8'($urandom_range(1, 255)));
         repeat (n - 1) hdr.push_back(8'($urandom));
         body_len = 5;
         cut = $urandom_range(hdr.size() - 1, hdr.size() + 4);
      end
      total = hdr.size() + int'(body_len);
      if (cut < 0 && $urandom_range(0, 7) == 0) cut = $urandom_range(0, total - 1);
      for (int i = 0; i < total; i++) begin
         b = (i < hdr.size()) ? hdr[i] : 8'($urandom);
         eoi = (i == cut) || (i == total - 1 && $urandom_range(0, 3) == 0);
         if (i == 0) send_item(b, cmd, xtag, eoi);
         else send_item(b, 1'($urandom), 8'($urandom), eoi);
         if (eoi || (i == 0 && cmd == dtlv_pkg::CMD_MATCH && xtag != tag)) break;
      end
   endtask

   // tag followed by an indefinite, oversized or non-minimal length
   task send_bad_header();
      int n;
      send_item(8'($urandom), dtlv_pkg::CMD_ANY, 8'($urandom), 1'b0);
      case ($urandom_range(0, 2))
         0: send_item(8'h80, 1'($urandom), 8'($urandom), 1'($urandom));
         1: send_item(8'h80 | 8'($urandom_range(MAX_OCTETS + 1, 127)), 1'($urandom),
                      8'($urandom), 1'($urandom));
         default: begin
            n = $urandom_range(2, MAX_OCTETS);
            send_item(8'h80 | 8'(n), 1'($urandom), 8'($urandom), 1'b0);
            for (int i = 0; i < n; i++)
               send_item((i == 0) ? 8'h00 : 8'($urandom), 1'($urandom), 8'($urandom),
                         (i == n - 1) ? 1'($urandom) : 1'b0);
         end
      endcase
   endtask

   // random bytes; the closing end-of-input byte always brings the parser back to tag wait
   task send_noise();
      repeat ($urandom_range(1, 6))
         send_item(8'($urandom), 1'($urandom), 8'($urandom), 1'b0);
      send_item(8'($urandom), 1'($urandom), 8'($urandom), 1'b1);
   endtask

   task send_random(input int count);
      int target;
      int pick;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) send_element();
         else if (pick < 9) send_bad_header();
         else send_noise();
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero-length element, tag required and present
      send_item(8'h30, dtlv_pkg::CMD_MATCH, 8'h30, 1'b0);
      send_item(8'h00, dtlv_pkg::CMD_ANY, 8'hFF, 1'b0);
      // tag mismatch
      send_item(8'hFF, dtlv_pkg::CMD_MATCH, 8'h00, 1'b0);
      // indefinite length
      send_item(8'h02, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h80, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      // too many length octets
      send_item(8'h04, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'hFF, dtlv_pkg::CMD_MATCH, 8'hFF, 1'b0);
      // non-minimal long form
      send_item(8'h30, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h82, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h00, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h05, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      // single long-form octet of zero is fine
      send_item(8'h31, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h81, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h00, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      // truncated on the tag itself
      send_item(8'h00, dtlv_pkg::CMD_ANY, 8'h00, 1'b1);
      // truncated between long-form octets
      send_item(8'h10, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h82, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h01, dtlv_pkg::CMD_ANY, 8'h00, 1'b1);
      // end of input on the last content byte is a complete element
      send_item(8'h05, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h02, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'h00, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'hFF, dtlv_pkg::CMD_ANY, 8'h00, 1'b1);
      // maximum long form, end of input right at the header
      send_item(8'hA0, dtlv_pkg::CMD_MATCH, 8'hA0, 1'b0);
      send_item(8'h84, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      repeat (3) send_item(8'hFF, dtlv_pkg::CMD_ANY, 8'h00, 1'b0);
      send_item(8'hFF, dtlv_pkg::CMD_ANY, 8'h00, 1'b1);
      drain();

      send_random(RANDOM_ITEMS / 3);
      drain();

      tx_idle_pct = 63;
      rx_idle_pct = 37;
      send_random(RANDOM_ITEMS / 3);
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_random(RANDOM_ITEMS / 3);
      drain();

      repeat (8) @(posedge clock);
      if (fail_count == 0 && queued_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
